[hdl/gom_pkg.sv]
// Shared types, constants and span arithmetic for the grid occupancy map.
// Used by gom_ctrl, gom_dp, grid_occupancy_map_core and the testbench; depends on nothing.
package gom_pkg;

  // Grid geometry. CELL_SIZE, GRID_COLS and GRID_ROWS must be powers of two.
  localparam int CELL_SIZE = 16;
  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;
  localparam int CELL_LOG2 = $clog2(CELL_SIZE);
  localparam int NUM_CELLS = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W    = $clog2(NUM_CELLS);
  localparam int COL_W     = $clog2(GRID_COLS);
  localparam int ROW_W     = $clog2(GRID_ROWS);
  localparam int AXIS_W    = (COL_W > ROW_W) ? COL_W : ROW_W;

  // Request field widths.
  localparam int OP_W  = 3;
  localparam int ID_W  = 8;
  localparam int POS_W = 10;
  localparam int OFF_W = 8;
  localparam int LEN_W = 9;
  localparam int IN_W  = 88;
  localparam int OUT_W = 16;

  // Pixel sums (position + offset + length) and the cell indexes they give.
  localparam int SUM_W  = POS_W + 3;
  localparam int CELL_W = SUM_W - CELL_LOG2;

  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_CLEAR  = 3'd0;
  localparam op_t OP_MARK   = 3'd1;
  localparam op_t OP_MOVE   = 3'd2;
  localparam op_t OP_REMOVE = 3'd3;
  localparam op_t OP_QUERY  = 3'd4;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOAD,
    ST_CLEAR,
    ST_WRITE,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_t;

  // One axis of a rectangle in cell units, clamped to the grid.
  typedef struct packed {
    logic [AXIS_W-1:0] lo;
    logic [AXIS_W-1:0] hi;
    logic              raw_empty;
    logic              outside;
    logic              none;
  } axis_t;

  typedef struct packed {
    axis_t x;
    axis_t y;
  } span_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_span;
    logic sel_old;
    logic step;
    logic we;
    logic wr_zero;
    logic clr_sel;
    logic clr_start;
    logic clr_step;
    logic capture;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic id_zero;
    logic span_none;
    logic last_cell;
    logic clr_last;
    logic match;
    logic occupied;
    logic out_free;
  } stat_t;

  // Division by CELL_SIZE that truncates toward zero, as signed integer math does.
  function automatic logic signed [CELL_W-1:0] trunc_div(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] fl;
    logic                    adj;
    fl  = v >>> CELL_LOG2;
    adj = v[SUM_W-1] && (v[CELL_LOG2-1:0] != '0);
    return fl[CELL_W-1:0] + CELL_W'(adj);
  endfunction

  // Cell range of one axis, its clamp to the grid and its flags.
  function automatic axis_t axis_of(input logic signed [SUM_W-1:0] start,
                                    input logic [LEN_W-1:0] len, input int cells);
    logic signed [SUM_W-1:0]  stop;
    logic signed [CELL_W-1:0] c0;
    logic signed [CELL_W-1:0] c1;
    logic signed [CELL_W-1:0] last;
    logic signed [CELL_W-1:0] lo;
    logic signed [CELL_W-1:0] hi;
    axis_t                    a;
    stop = start + $signed({{(SUM_W-LEN_W){1'b0}}, len}) - $signed(SUM_W'(1));
    c0   = trunc_div(start);
    c1   = trunc_div(stop);
    last = $signed(CELL_W'(cells - 1));
    lo   = (c0 < 0) ? '0 : c0;
    hi   = (c1 > last) ? last : c1;
    a.raw_empty = c1 < c0;
    a.outside   = (c0 < 0) || (c1 > last);
    a.none      = (c1 < c0) || (hi < lo);
    a.lo        = lo[AXIS_W-1:0];
    a.hi        = hi[AXIS_W-1:0];
    return a;
  endfunction

  function automatic span_t span_of(input logic signed [SUM_W-1:0] x,
                                    input logic signed [SUM_W-1:0] y,
                                    input logic [LEN_W-1:0] w, input logic [LEN_W-1:0] h);
    span_t s;
    s.x = axis_of(x, w, GRID_COLS);
    s.y = axis_of(y, h, GRID_ROWS);
    return s;
  endfunction

  // A rectangle is clipped when it covers cells and some of them lie off the grid.
  function automatic logic span_clipped(input span_t s);
    return !(s.x.raw_empty || s.y.raw_empty) && (s.x.outside || s.y.outside);
  endfunction

endpackage

[hdl/gom_ctrl.sv]
// Controller state machine of the grid occupancy map.
// Depends on gom_pkg; drives gom_dp through gom_pkg::cmd_t and reads gom_pkg::stat_t.
module gom_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  gom_pkg::stat_t stat,
  output gom_pkg::cmd_t  cmd
);

  gom_pkg::state_t state, state_next;
  logic            second, second_next;
  logic            is_move;
  logic            is_write;

  // State register and move phase flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= gom_pkg::ST_INIT;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

  assign is_move  = (stat.op == gom_pkg::OP_MOVE);
  assign is_write = (stat.op == gom_pkg::OP_MARK) || (is_move && second);

  // Next state and commands.
  always_comb begin
    state_next  = state;
    second_next = second;
    s_tready    = 1'b0;
    cmd         = '0;
    cmd.sel_old = is_move && !second;
    unique case (state)
      gom_pkg::ST_INIT: begin
        cmd.clr_sel  = 1'b1;
        cmd.we       = 1'b1;
        cmd.wr_zero  = 1'b1;
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = gom_pkg::ST_IDLE;
        end
      end
      gom_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept    = 1'b1;
          cmd.clr_start = 1'b1;
          second_next   = 1'b0;
          state_next    = gom_pkg::ST_LOAD;
        end
      end
      gom_pkg::ST_LOAD: begin
        cmd.load_span = 1'b1;
        if (stat.op == gom_pkg::OP_CLEAR) begin
          state_next = gom_pkg::ST_CLEAR;
        end else if (stat.op == gom_pkg::OP_QUERY) begin
          state_next = stat.span_none ? gom_pkg::ST_DONE : gom_pkg::ST_READ;
        end else if (stat.op == gom_pkg::OP_MARK || stat.op == gom_pkg::OP_MOVE ||
                     stat.op == gom_pkg::OP_REMOVE) begin
          if (stat.id_zero) begin
            state_next = gom_pkg::ST_DONE;
          end else if (stat.span_none) begin
            // An empty old rectangle moves straight on to marking the new one.
            if (is_move && !second) begin
              second_next = 1'b1;
            end else begin
              state_next = gom_pkg::ST_DONE;
            end
          end else begin
            state_next = is_write ? gom_pkg::ST_WRITE : gom_pkg::ST_READ;
          end
        end else begin
          state_next = gom_pkg::ST_DONE;
        end
      end
      gom_pkg::ST_CLEAR: begin
        cmd.clr_sel  = 1'b1;
        cmd.we       = 1'b1;
        cmd.wr_zero  = 1'b1;
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = gom_pkg::ST_DONE;
        end
      end
      gom_pkg::ST_WRITE: begin
        cmd.we   = 1'b1;
        cmd.step = 1'b1;
        if (stat.last_cell) begin
          state_next = gom_pkg::ST_DONE;
        end
      end
      gom_pkg::ST_READ: begin
        state_next = gom_pkg::ST_CHECK;
      end
      gom_pkg::ST_CHECK: begin
        if (stat.op == gom_pkg::OP_QUERY) begin
          // The first foreign occupant ends the scan.
          if (stat.occupied) begin
            cmd.capture = 1'b1;
            state_next  = gom_pkg::ST_DONE;
          end else if (stat.last_cell) begin
            state_next = gom_pkg::ST_DONE;
          end else begin
            cmd.step   = 1'b1;
            state_next = gom_pkg::ST_READ;
          end
        end else begin
          // Clear the cell only where this entity owns it.
          cmd.we      = stat.match;
          cmd.wr_zero = 1'b1;
          if (stat.last_cell) begin
            if (is_move) begin
              second_next = 1'b1;
              state_next  = gom_pkg::ST_LOAD;
            end else begin
              state_next = gom_pkg::ST_DONE;
            end
          end else begin
            cmd.step   = 1'b1;
            state_next = gom_pkg::ST_READ;
          end
        end
      end
      gom_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = gom_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gom_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/gom_dp.sv]
// Datapath of the grid occupancy map: request registers, span math, cell walk
// counters, the cell owner memory and the result register. Depends on gom_pkg.
module gom_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [gom_pkg::IN_W-1:0]     s_tdata,
  input  gom_pkg::cmd_t                cmd,
  output gom_pkg::stat_t               stat,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [gom_pkg::OUT_W-1:0]    m_tdata
);

  gom_pkg::op_t                  op;
  logic [gom_pkg::ID_W-1:0]      id;
  logic [gom_pkg::POS_W-1:0]     pos_x, pos_y, old_x, old_y;
  logic [gom_pkg::OFF_W-1:0]     off_x, off_y;
  logic [gom_pkg::LEN_W-1:0]     rect_w, rect_h;

  logic signed [gom_pkg::SUM_W-1:0] offx, offy, new_x, new_y, prev_x, prev_y;
  logic signed [gom_pkg::SUM_W-1:0] raw_x, raw_y, qry_x, qry_y;
  gom_pkg::span_t                   sp_new, sp_old, sp_qry, sp_sel;
  logic                             clip_now;

  logic [gom_pkg::COL_W-1:0]  cx, x_hi;
  logic [gom_pkg::ROW_W-1:0]  cy, y_lo, y_hi;
  logic [gom_pkg::ADDR_W-1:0] clr, addr;

  logic [gom_pkg::ID_W-1:0] mem [gom_pkg::NUM_CELLS];
  logic [gom_pkg::ID_W-1:0] rdata;
  logic [gom_pkg::ID_W-1:0] occ;

  logic                     af_q, clip_q;
  logic [gom_pkg::ID_W-1:0] occ_q;

  // Request registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op     <= s_tdata[2:0];
      id     <= s_tdata[10:3];
      pos_x  <= s_tdata[20:11];
      pos_y  <= s_tdata[30:21];
      old_x  <= s_tdata[40:31];
      old_y  <= s_tdata[50:41];
      off_x  <= s_tdata[58:51];
      off_y  <= s_tdata[66:59];
      rect_w <= s_tdata[75:67];
      rect_h <= s_tdata[84:76];
    end
  end

  // Pixel origins of the new, old and query rectangles.
  always_comb begin
    offx   = {{(gom_pkg::SUM_W-gom_pkg::OFF_W){off_x[gom_pkg::OFF_W-1]}}, off_x};
    offy   = {{(gom_pkg::SUM_W-gom_pkg::OFF_W){off_y[gom_pkg::OFF_W-1]}}, off_y};
    raw_x  = $signed({{(gom_pkg::SUM_W-gom_pkg::POS_W){1'b0}}, pos_x});
    raw_y  = $signed({{(gom_pkg::SUM_W-gom_pkg::POS_W){1'b0}}, pos_y});
    new_x  = raw_x + offx;
    new_y  = raw_y + offy;
    prev_x = $signed({{(gom_pkg::SUM_W-gom_pkg::POS_W){1'b0}}, old_x}) + offx;
    prev_y = $signed({{(gom_pkg::SUM_W-gom_pkg::POS_W){1'b0}}, old_y}) + offy;
    // A query without a source ignores the collider offset.
    qry_x  = (id != '0) ? new_x : raw_x;
    qry_y  = (id != '0) ? new_y : raw_y;
    sp_new = gom_pkg::span_of(new_x, new_y, rect_w, rect_h);
    sp_old = gom_pkg::span_of(prev_x, prev_y, rect_w, rect_h);
    sp_qry = gom_pkg::span_of(qry_x, qry_y, rect_w, rect_h);
    if (cmd.sel_old) begin
      sp_sel = sp_old;
    end else if (op == gom_pkg::OP_QUERY) begin
      sp_sel = sp_qry;
    end else begin
      sp_sel = sp_new;
    end
  end

  // Clip flag of the result, over every rectangle the request uses.
  always_comb begin
    case (op) inside
      gom_pkg::OP_MARK, gom_pkg::OP_REMOVE: clip_now = gom_pkg::span_clipped(sp_new);
      gom_pkg::OP_MOVE: begin
        clip_now = gom_pkg::span_clipped(sp_old) || gom_pkg::span_clipped(sp_new);
      end
      gom_pkg::OP_QUERY: clip_now = gom_pkg::span_clipped(sp_qry);
      default:           clip_now = 1'b0;
    endcase
  end

  // Cell walk: columns outer, rows inner, within the clamped rectangle.
  always_ff @(posedge clk) begin
    if (cmd.load_span) begin
      cx   <= sp_sel.x.lo[gom_pkg::COL_W-1:0];
      x_hi <= sp_sel.x.hi[gom_pkg::COL_W-1:0];
      cy   <= sp_sel.y.lo[gom_pkg::ROW_W-1:0];
      y_lo <= sp_sel.y.lo[gom_pkg::ROW_W-1:0];
      y_hi <= sp_sel.y.hi[gom_pkg::ROW_W-1:0];
    end else if (cmd.step) begin
      if (cy == y_hi) begin
        cy <= y_lo;
        cx <= cx + gom_pkg::COL_W'(1);
      end else begin
        cy <= cy + gom_pkg::ROW_W'(1);
      end
    end
  end

  // Sweep counter for the clearing passes.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      clr <= '0;
    end else if (cmd.clr_step) begin
      clr <= clr + gom_pkg::ADDR_W'(1);
    end
  end

  always_comb begin
    if (cmd.clr_sel) begin
      addr = clr;
    end else begin
      addr = gom_pkg::ADDR_W'(cy) * gom_pkg::ADDR_W'(gom_pkg::GRID_COLS)
           + gom_pkg::ADDR_W'(cx);
    end
  end

  // Cell owner memory, one access per cycle, registered read.
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[addr] <= cmd.wr_zero ? '0 : id;
    end
    rdata <= mem[addr];
  end

  // Occupant found by the query scan.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      occ <= '0;
    end else if (cmd.capture) begin
      occ <= rdata;
    end
  end

  // Result register; a new request can start while this one waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      af_q   <= (op == gom_pkg::OP_QUERY) && (occ == '0);
      occ_q  <= occ;
      clip_q <= clip_now;
    end
  end

  assign m_tdata = {6'b0, clip_q, occ_q, af_q};

  // Status toward the controller.
  always_comb begin
    stat.op        = op;
    stat.id_zero   = (id == '0);
    stat.span_none = sp_sel.x.none || sp_sel.y.none;
    stat.last_cell = (cx == x_hi) && (cy == y_hi);
    stat.clr_last  = (clr == gom_pkg::ADDR_W'(gom_pkg::NUM_CELLS - 1));
    stat.match     = (rdata == id);
    stat.occupied  = (rdata != '0) && (rdata != id);
    stat.out_free  = !m_tvalid || m_tready;
  end

endmodule

[hdl/grid_occupancy_map_core.sv]
// Grid occupancy map: one request in, one result out per request.
// A clear zeroes every cell; mark writes each covered cell; remove and query read and check
// each cell visited (a query stops at the first foreign occupant); move frees the cells of
// the old rectangle that it owns, then marks the new one. Owner none (not for a query) or no
// covered cell skips the cell walk. The next request is taken in the cycle after its result
// is loaded. After reset a pass over every cell zeroes the memory before any request is taken.
module grid_occupancy_map_core (
  input  logic                      clk,
  input  logic                      rst,
  // operation, entity_id, pos_x, pos_y, old_x, old_y, offset_x, offset_y,
  // rect_width, rect_height (lowest bits first), zero filled to 88 bits
  input  logic [gom_pkg::IN_W-1:0]  s_tdata,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // area_free, occupant, clipped (lowest bits first), zero filled to 16 bits
  output logic [gom_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready
);

  gom_pkg::cmd_t  cmd;
  gom_pkg::stat_t stat;

  gom_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gom_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Two requests are never accepted back to back.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted twice in a row");

  // A result appears only when the controller finishes a request.
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.finish))
    else $error("result valid without a finished request");

  // A free area never names an occupant.
  a_free_means_no_owner: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[8:1] == '0))
    else $error("area reported free with an occupant");

  // The memory is never written while a request is being accepted.
  a_no_write_in_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cmd.we)
    else $error("cell write while idle");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for grid_occupancy_map_core: streams map requests and checks
// every result against a scoreboard that keeps its own copy of the cell owners.
// Depends on gom_pkg for field widths, opcodes and grid geometry, and on the core itself.
module testbench;

  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int RANDOM_REQUESTS = 900;
  localparam int DRAIN_CYCLES    = 5000;
  localparam int FEW_IDS         = 6;

  // Opcodes the block does not define; it must answer them with an all-zero result.
  localparam gom_pkg::op_t OP_SPARE_LO = 3'd5;
  localparam gom_pkg::op_t OP_SPARE_HI = 3'd7;

  // Request layout on s_tdata, last member in the lowest bits.
  typedef struct packed {
    logic [2:0]                        fill;
    logic [gom_pkg::LEN_W-1:0]         rect_height;
    logic [gom_pkg::LEN_W-1:0]         rect_width;
    logic signed [gom_pkg::OFF_W-1:0]  offset_y;
    logic signed [gom_pkg::OFF_W-1:0]  offset_x;
    logic [gom_pkg::POS_W-1:0]         old_y;
    logic [gom_pkg::POS_W-1:0]         old_x;
    logic [gom_pkg::POS_W-1:0]         pos_y;
    logic [gom_pkg::POS_W-1:0]         pos_x;
    logic [gom_pkg::ID_W-1:0]          entity_id;
    gom_pkg::op_t                      operation;
  } request_t;

  // Result layout on m_tdata, last member in the lowest bits.
  typedef struct packed {
    logic [5:0]               fill;
    logic                     clipped;
    logic [gom_pkg::ID_W-1:0] occupant;
    logic                     area_free;
  } result_t;

  // Rectangle in cell units, before any clamp to the grid.
  typedef struct {
    int x0;
    int y0;
    int x1;
    int y1;
  } area_t;

  // Keeps the expected owner of every grid position and the results still owed.
  class occupancy_scoreboard;
    logic [gom_pkg::ID_W-1:0] owner_map [gom_pkg::NUM_CELLS];
    result_t                  expected_results [$];
    int unsigned              errors;
    int unsigned              op_count [8];
    int unsigned              hits;
    int unsigned              clips;

    function new();
      wipe();
    endfunction

    function void wipe();
      foreach (owner_map[i]) owner_map[i] = '0;
    endfunction

    // Pixel rectangle to cell bounds; SystemVerilog division truncates toward zero.
    function area_t cell_area(int x, int y, int w, int h);
      area_t a;
      a.x0 = x / gom_pkg::CELL_SIZE;
      a.y0 = y / gom_pkg::CELL_SIZE;
      a.x1 = (x + w - 1) / gom_pkg::CELL_SIZE;
      a.y1 = (y + h - 1) / gom_pkg::CELL_SIZE;
      return a;
    endfunction

    function bit off_grid(area_t a);
      if (a.x1 < a.x0 || a.y1 < a.y0) return 1'b0;
      return a.x0 < 0 || a.y0 < 0 || a.x1 >= gom_pkg::GRID_COLS || a.y1 >= gom_pkg::GRID_ROWS;
    endfunction

    function bit on_grid(int cx, int cy);
      return cx >= 0 && cy >= 0 && cx < gom_pkg::GRID_COLS && cy < gom_pkg::GRID_ROWS;
    endfunction

    // Either writes the owner everywhere, or frees only the positions it holds.
    function void paint(area_t a, logic [gom_pkg::ID_W-1:0] id, bit erase_only);
      int idx;
      for (int cx = a.x0; cx <= a.x1; cx++) begin
        for (int cy = a.y0; cy <= a.y1; cy++) begin
          if (on_grid(cx, cy)) begin
            idx = cy * gom_pkg::GRID_COLS + cx;
            if (!erase_only) owner_map[idx] = id;
            else if (owner_map[idx] == id) owner_map[idx] = '0;
          end
        end
      end
    endfunction

    // Column-major scan for the first owner that is neither empty nor the source.
    function logic [gom_pkg::ID_W-1:0] first_intruder(area_t a,
                                                      logic [gom_pkg::ID_W-1:0] source);
      logic [gom_pkg::ID_W-1:0] o;
      for (int cx = a.x0; cx <= a.x1; cx++) begin
        for (int cy = a.y0; cy <= a.y1; cy++) begin
          if (on_grid(cx, cy)) begin
            o = owner_map[cy * gom_pkg::GRID_COLS + cx];
            if (o != '0 && o != source) return o;
          end
        end
      end
      return '0;
    endfunction

    // Applies one accepted request to the map and queues the result it must produce.
    function void note_request(request_t r);
      result_t want;
      area_t   here;
      area_t   prev;
      int      ox;
      int      oy;
      want = '0;
      ox   = int'(r.offset_x);
      oy   = int'(r.offset_y);
      here = cell_area(int'(r.pos_x) + ox, int'(r.pos_y) + oy,
                       int'(r.rect_width), int'(r.rect_height));
      case (r.operation)
        gom_pkg::OP_CLEAR: wipe();
        gom_pkg::OP_MARK: begin
          want.clipped = off_grid(here);
          if (r.entity_id != '0) paint(here, r.entity_id, 1'b0);
        end
        gom_pkg::OP_MOVE: begin
          prev = cell_area(int'(r.old_x) + ox, int'(r.old_y) + oy,
                           int'(r.rect_width), int'(r.rect_height));
          want.clipped = off_grid(prev) || off_grid(here);
          if (r.entity_id != '0) begin
            paint(prev, r.entity_id, 1'b1);
            paint(here, r.entity_id, 1'b0);
          end
        end
        gom_pkg::OP_REMOVE: begin
          want.clipped = off_grid(here);
          if (r.entity_id != '0) paint(here, r.entity_id, 1'b1);
        end
        gom_pkg::OP_QUERY: begin
          // Without a source the collider offset does not apply.
          if (r.entity_id == '0) begin
            here = cell_area(int'(r.pos_x), int'(r.pos_y),
                             int'(r.rect_width), int'(r.rect_height));
          end
          want.occupant  = first_intruder(here, r.entity_id);
          want.area_free = (want.occupant == '0);
          want.clipped   = off_grid(here);
        end
        default: ;
      endcase
      op_count[r.operation]++;
      if (want.occupant != '0) hits++;
      if (want.clipped) clips++;
      expected_results.push_back(want);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result %h arrived with no request outstanding", got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("area_free", int'(want.area_free), int'(got.area_free));
      compare_field("occupant", int'(want.occupant), int'(got.occupant));
      compare_field("clipped", int'(want.clipped), int'(got.clipped));
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic [gom_pkg::IN_W-1:0]    s_tdata = '0;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [gom_pkg::OUT_W-1:0]   m_tdata;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;

  occupancy_scoreboard board = new();

  // Last rectangle placed by each entity, used to build well-formed moves and removes.
  request_t placed [256];
  bit       placed_ok [256];

  logic [10:0] ready_phase = '0;
  int          idle_cycles = 0;

  grid_occupancy_map_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Every accepted request feeds the predictor; every accepted result is checked.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) board.note_request(request_t'(s_tdata));
    if (!rst && m_tvalid && m_tready) board.check_result(result_t'(m_tdata));
  end

  // The receiver cycles through always-ready, random, long-stall and sparse-stall phases.
  always @(posedge clk) begin
    ready_phase <= ready_phase + 11'd1;
    case (ready_phase[10:9])
      2'd0:    m_tready <= 1'b1;
      2'd1:    m_tready <= ($urandom_range(0, 1) == 1);
      2'd2:    m_tready <= ready_phase[4];
      default: m_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Ends the run if no request and no result moves for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Holds the request on the bus until it is taken; valid stays high for the caller.
  task automatic send_request(input request_t r);
    s_tdata  <= r;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stops sending until every outstanding result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (board.expected_results.size() != 0);
  endtask

  function automatic request_t make_request(gom_pkg::op_t op, int id, int px, int py,
                                            int ox, int oy, int w, int h,
                                            int qx = 0, int qy = 0);
    request_t r;
    r             = '0;
    r.operation   = op;
    r.entity_id   = id[7:0];
    r.pos_x       = px[9:0];
    r.pos_y       = py[9:0];
    r.old_x       = qx[9:0];
    r.old_y       = qy[9:0];
    r.offset_x    = ox[7:0];
    r.offset_y    = oy[7:0];
    r.rect_width  = w[8:0];
    r.rect_height = h[8:0];
    return r;
  endfunction

  // Mostly well-formed traffic among a few entities, with some pure noise mixed in.
  function automatic request_t random_request();
    request_t    r;
    logic [95:0] noise;
    int          pick;
    int          t;
    noise  = {$urandom, $urandom, $urandom};
    r      = noise[gom_pkg::IN_W-1:0];
    r.fill = '0;
    if ($urandom_range(0, 99) < 10) return r;

    pick = $urandom_range(0, 99);
    if (pick < 10) r.entity_id = '0;
    else if (pick < 75) r.entity_id = gom_pkg::ID_W'($urandom_range(1, FEW_IDS));
    if ($urandom_range(0, 1) == 0) begin
      r.offset_x = '0;
      r.offset_y = '0;
    end
    if ($urandom_range(0, 9) < 6) begin
      r.pos_x = gom_pkg::POS_W'($urandom_range(0, 255));
      r.pos_y = gom_pkg::POS_W'($urandom_range(0, 255));
    end
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      r.rect_width  = gom_pkg::LEN_W'($urandom_range(1, 48));
      r.rect_height = gom_pkg::LEN_W'($urandom_range(1, 48));
    end else if (pick < 97) begin
      r.rect_width  = gom_pkg::LEN_W'($urandom_range(1, 256));
      r.rect_height = gom_pkg::LEN_W'($urandom_range(1, 256));
    end

    pick = $urandom_range(0, 99);
    if (pick < 1) begin
      r.operation = gom_pkg::OP_CLEAR;
      foreach (placed_ok[i]) placed_ok[i] = 1'b0;
    end else if (pick < 26) begin
      r.operation = gom_pkg::OP_MARK;
    end else if (pick < 51) begin
      if (placed_ok[r.entity_id] && $urandom_range(0, 3) != 0) begin
        r = placed[r.entity_id];
        r.old_x = r.pos_x;
        r.old_y = r.pos_y;
        r.pos_x = r.old_x + 10'($urandom_range(0, 96)) - 10'd48;
        r.pos_y = r.old_y + 10'($urandom_range(0, 96)) - 10'd48;
      end
      r.operation = gom_pkg::OP_MOVE;
    end else if (pick < 63) begin
      if (placed_ok[r.entity_id] && $urandom_range(0, 4) != 0) r = placed[r.entity_id];
      r.operation = gom_pkg::OP_REMOVE;
      placed_ok[r.entity_id] = 1'b0;
    end else if (pick < 96) begin
      t = $urandom_range(1, FEW_IDS);
      if (placed_ok[t] && $urandom_range(0, 1) == 0) begin
        r = placed[t];
        r.entity_id = gom_pkg::ID_W'($urandom_range(0, FEW_IDS));
      end
      r.operation = gom_pkg::OP_QUERY;
    end else begin
      r.operation = gom_pkg::op_t'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end

    if ((r.operation == gom_pkg::OP_MARK || r.operation == gom_pkg::OP_MOVE) &&
        r.entity_id != '0) begin
      placed[r.entity_id]    = r;
      placed_ok[r.entity_id] = 1'b1;
    end
    return r;
  endfunction

  initial begin
    int sent;
    int burst;
    bit steady;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty map, own and foreign owners, grid edges, truncation of
    // negative pixels, empty rectangles, owner none, unused opcodes and a full clear.
    send_request(make_request(gom_pkg::OP_QUERY, 0, 0, 0, 0, 0, 16, 16));
    send_request(make_request(gom_pkg::OP_MARK, 1, 0, 0, 0, 0, 1, 1));
    send_request(make_request(gom_pkg::OP_QUERY, 0, 0, 0, 0, 0, 1, 1));
    send_request(make_request(gom_pkg::OP_QUERY, 1, 0, 0, 0, 0, 1, 1));
    send_request(make_request(gom_pkg::OP_MARK, 255, 1023, 1023, 0, 0, 256, 256));
    send_request(make_request(gom_pkg::OP_MARK, 2, 0, 0, -128, -128, 256, 256));
    send_request(make_request(gom_pkg::OP_MARK, 3, 0, 32, -5, -5, 1, 1));
    send_request(make_request(gom_pkg::OP_QUERY, 0, 0, 16, 0, 0, 1, 16));
    send_request(make_request(gom_pkg::OP_MARK, 4, 100, 100, 0, 0, 0, 16));
    send_request(make_request(gom_pkg::OP_REMOVE, 4, 0, 0, -128, 0, 0, 16));
    send_request(make_request(gom_pkg::OP_MARK, 0, 0, 0, 0, 0, 64, 64));
    send_request(make_request(gom_pkg::OP_MARK, 0, 0, 0, -1, -1, 64, 64));
    send_request(make_request(gom_pkg::OP_MOVE, 1, 500, 500, 0, 0, 1, 1, 0, 0));
    send_request(make_request(gom_pkg::OP_QUERY, 0, 0, 0, 0, 0, 1, 1));
    send_request(make_request(gom_pkg::OP_QUERY, 0, 500, 500, 0, 0, 1, 1));
    send_request(make_request(gom_pkg::OP_MOVE, 1, 1023, 1023, 127, 127, 40, 40, 500, 500));
    send_request(make_request(gom_pkg::OP_REMOVE, 2, 0, 0, -128, -128, 256, 256));
    send_request(make_request(gom_pkg::OP_REMOVE, 7, 1000, 1000, 0, 0, 64, 64));
    send_request(make_request(gom_pkg::OP_QUERY, 9, 1000, 1000, 127, 127, 256, 256));
    send_request(make_request(gom_pkg::OP_QUERY, 255, 1000, 1000, 127, 127, 256, 256));
    for (int op = int'(OP_SPARE_LO); op <= int'(OP_SPARE_HI); op++)
      send_request(make_request(gom_pkg::op_t'(op), 255, 1023, 1023, 127, -128, 511, 511));
    send_request(make_request(gom_pkg::OP_CLEAR, 255, 0, 0, 0, 0, 16, 16));
    send_request(make_request(gom_pkg::OP_QUERY, 0, 0, 0, 0, 0, 511, 511));
    send_request(make_request(gom_pkg::OP_MARK, 128, 1023, 0, 0, 0, 511, 1));
    drain();

    // Random part in bursts; some stretches run without gaps, one pause drains fully.
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      burst  = $urandom_range(1, 24);
      steady = ((sent / 150) % 3 == 0);
      for (int i = 0; i < burst && sent < RANDOM_REQUESTS; i++) begin
        send_request(random_request());
        sent++;
      end
      if (sent >= RANDOM_REQUESTS / 2 && sent - burst < RANDOM_REQUESTS / 2) drain();
      else if (!steady) pause($urandom_range(0, 12));
    end
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d clear, %0d mark, %0d move, %0d remove, %0d query.",
             board.op_count.sum(), board.op_count[gom_pkg::OP_CLEAR],
             board.op_count[gom_pkg::OP_MARK], board.op_count[gom_pkg::OP_MOVE],
             board.op_count[gom_pkg::OP_REMOVE], board.op_count[gom_pkg::OP_QUERY]);
    $display("Queries that met another entity: %0d; results with off-grid cells: %0d.",
             board.hits, board.clips);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[grid_occupancy_map_core.f]
hdl/gom_pkg.sv
hdl/gom_ctrl.sv
hdl/gom_dp.sv
hdl/grid_occupancy_map_core.sv
bench/testbench.sv
